### rtl/core/rgbhsv_pkg.sv
package rgbhsv_pkg;

    // Hue scale: 60 degrees is 3840 units of 1/64 degree.
    localparam logic [11:0] HUE_SIXTH = 12'd3840;
    localparam logic [14:0] HUE_BASE_RED = 15'd0;
    localparam logic [14:0] HUE_BASE_GREEN = 15'd7680;
    localparam logic [14:0] HUE_BASE_BLUE = 15'd15360;
    localparam logic [14:0] HUE_FULL = 15'd23040;
    localparam logic [7:0] SAT_SCALE = 8'd255;

    // One quotient bit per cell; both quotients fit in this many bits.
    localparam int DIV_STEPS = 12;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgbhsv_rgb_t;

    typedef struct packed {
        logic [14:0] hue;
        logic [7:0]  saturation;
        logic [7:0]  brightness;
    } rgbhsv_hsv_t;

    // One division in flight: divisor, partial remainder and a register
    // that holds the dividend bits still to come in its upper part and
    // the quotient bits already found in its lower part.
    typedef struct packed {
        logic [7:0]           divisor;
        logic [7:0]           rem;
        logic [DIV_STEPS-1:0] num_quo;
    } rgbhsv_div_t;

    // Everything an item carries down the cell chain.
    typedef struct packed {
        rgbhsv_div_t hue_div;
        rgbhsv_div_t sat_div;
        logic [14:0] base;
        logic        negative;
        logic        gray;
        logic [7:0]  brightness;
    } rgbhsv_work_t;

endpackage

### rtl/core/rgbhsv_prep.sv
module rgbhsv_prep
    import rgbhsv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  logic         valid_in,
    input  rgbhsv_rgb_t  pixel,
    output logic         valid,
    output rgbhsv_work_t work
);

    logic         valid_reg;
    rgbhsv_work_t work_reg;
    rgbhsv_work_t work_next;

    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  delta;
    logic [7:0]  diff;
    logic [19:0] hue_num;
    logic [19:0] sat_num;

    always_comb
    begin
        mx = pixel.red;
        mn = pixel.red;
        if (pixel.green > mx)
        begin
            mx = pixel.green;
        end
        if (pixel.blue > mx)
        begin
            mx = pixel.blue;
        end
        if (pixel.green < mn)
        begin
            mn = pixel.green;
        end
        if (pixel.blue < mn)
        begin
            mn = pixel.blue;
        end
        delta = mx - mn;

        // Sector of the largest channel; red wins ties, then green.
        priority if (mx == pixel.red)
        begin
            if (pixel.green >= pixel.blue)
            begin
                work_next.base = HUE_BASE_RED;
                work_next.negative = 1'b0;
                diff = pixel.green - pixel.blue;
            end
            else
            begin
                work_next.base = HUE_FULL;
                work_next.negative = 1'b1;
                diff = pixel.blue - pixel.green;
            end
        end
        else if (mx == pixel.green)
        begin
            work_next.base = HUE_BASE_GREEN;
            if (pixel.blue >= pixel.red)
            begin
                work_next.negative = 1'b0;
                diff = pixel.blue - pixel.red;
            end
            else
            begin
                work_next.negative = 1'b1;
                diff = pixel.red - pixel.blue;
            end
        end
        else
        begin
            work_next.base = HUE_BASE_BLUE;
            if (pixel.red >= pixel.green)
            begin
                work_next.negative = 1'b0;
                diff = pixel.red - pixel.green;
            end
            else
            begin
                work_next.negative = 1'b1;
                diff = pixel.green - pixel.red;
            end
        end

        hue_num = 20'(diff) * 20'(HUE_SIXTH);
        sat_num = 20'(delta) * 20'(SAT_SCALE);

        work_next.gray = (delta == 8'd0);
        work_next.brightness = mx;

        // A gray pixel divides by one so that the chain never sees zero;
        // its quotients are discarded at the end.
        work_next.hue_div.divisor = work_next.gray ? 8'd1 : delta;
        work_next.hue_div.rem = hue_num[19:DIV_STEPS];
        work_next.hue_div.num_quo = hue_num[DIV_STEPS-1:0];
        work_next.sat_div.divisor = work_next.gray ? 8'd1 : mx;
        work_next.sat_div.rem = sat_num[19:DIV_STEPS];
        work_next.sat_div.num_quo = sat_num[DIV_STEPS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && valid_in)
        begin
            work_reg <= work_next;
        end
    end

    assign valid = valid_reg;
    assign work = work_reg;

endmodule

### rtl/core/rgbhsv_cell.sv
module rgbhsv_cell
    import rgbhsv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  logic         valid_in,
    input  rgbhsv_work_t work_in,
    output logic         valid,
    output rgbhsv_work_t work
);

    logic         valid_reg;
    rgbhsv_work_t work_reg;
    rgbhsv_work_t work_next;

    // One restoring division step: bring down the next dividend bit,
    // subtract the divisor if it fits, and shift in the quotient bit.
    function automatic rgbhsv_div_t div_step(input rgbhsv_div_t d);
        rgbhsv_div_t r;
        logic [8:0]  trial;
        logic [8:0]  diff;
        logic        fits;
        trial = {d.rem, d.num_quo[DIV_STEPS-1]};
        diff = trial - {1'b0, d.divisor};
        fits = (trial >= {1'b0, d.divisor});
        r.divisor = d.divisor;
        r.rem = fits ? diff[7:0] : trial[7:0];
        r.num_quo = {d.num_quo[DIV_STEPS-2:0], fits};
        return r;
    endfunction

    always_comb
    begin
        work_next = work_in;
        work_next.hue_div = div_step(work_in.hue_div);
        work_next.sat_div = div_step(work_in.sat_div);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && valid_in)
        begin
            work_reg <= work_next;
        end
    end

    assign valid = valid_reg;
    assign work = work_reg;

endmodule

### rtl/core/rgb_to_hsv_pixel.sv
// Channel | Signals                    | Direction | Item
// --------+----------------------------+-----------+------------------------------
// rgb     | rgb_valid, rgb_stall, rgb  | input     | red, green, blue (8 bits each)
// hsv     | hsv_valid, hsv_stall, hsv  | output    | hue (15), saturation, brightness
//
// The block takes one item per clock and returns one item per clock while hsv
// is not stalled. There is one preparation stage, twelve division cells that each
// produce one quotient bit of both divisions, and the output register.
// Reset (rst_n low, asynchronous) empties every stage; payload is not cleared.
// A stall on hsv holds the output register; stages behind it keep moving while
// an empty stage lies ahead of them, so rgb_stall rises only when the whole
// chain is full.
module rgb_to_hsv_pixel
    import rgbhsv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rgb_valid,
    output logic        rgb_stall,
    input  rgbhsv_rgb_t rgb,
    output logic        hsv_valid,
    input  logic        hsv_stall,
    output rgbhsv_hsv_t hsv
);

    // Stage 0 is the preparation stage, stages 1 to DIV_STEPS are cells, and
    // the last stage is the output register.
    localparam int LAST = DIV_STEPS + 1;

    logic         stage_valid [0:DIV_STEPS];
    rgbhsv_work_t stage_work  [0:DIV_STEPS];
    logic [LAST:0] load;

    logic        out_valid_reg;
    rgbhsv_hsv_t out_reg;
    rgbhsv_hsv_t out_next;

    // A stage loads when it is empty or when its item moves on this cycle.
    always_comb
    begin
        load[LAST] = !out_valid_reg || !hsv_stall;
        for (int i = DIV_STEPS; i >= 0; i--)
        begin
            load[i] = !stage_valid[i] || load[i+1];
        end
    end

    assign rgb_stall = !load[0];

    rgbhsv_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load[0]),
        .valid_in (rgb_valid),
        .pixel    (rgb),
        .valid    (stage_valid[0]),
        .work     (stage_work[0])
    );

    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_cell
        rgbhsv_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .load     (load[k]),
            .valid_in (stage_valid[k-1]),
            .work_in  (stage_work[k-1]),
            .valid    (stage_valid[k]),
            .work     (stage_work[k])
        );
    end

    // After the last cell both registers hold whole quotients. The hue
    // quotient never exceeds one sector, so the add or subtract stays in range.
    always_comb
    begin
        out_next.brightness = stage_work[DIV_STEPS].brightness;
        if (stage_work[DIV_STEPS].gray)
        begin
            out_next.hue = 15'd0;
            out_next.saturation = 8'd0;
        end
        else
        begin
            if (stage_work[DIV_STEPS].negative)
            begin
                out_next.hue = stage_work[DIV_STEPS].base
                    - 15'(stage_work[DIV_STEPS].hue_div.num_quo);
            end
            else
            begin
                out_next.hue = stage_work[DIV_STEPS].base
                    + 15'(stage_work[DIV_STEPS].hue_div.num_quo);
            end
            out_next.saturation = stage_work[DIV_STEPS].sat_div.num_quo[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load[LAST])
        begin
            out_valid_reg <= stage_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[LAST] && stage_valid[DIV_STEPS])
        begin
            out_reg <= out_next;
        end
    end

    assign hsv_valid = out_valid_reg;
    assign hsv = out_reg;

    // Hue always stays below a full turn.
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid |-> (hsv.hue < HUE_FULL))
        else $error("hue out of range");

    // A black pixel is gray: no hue and no saturation.
    a_black_gray: assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_valid && (hsv.brightness == 8'd0)) |->
            ((hsv.hue == 15'd0) && (hsv.saturation == 8'd0)))
        else $error("black pixel with hue or saturation");

    // The input side is held off only while the first stage is occupied.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_stall |-> stage_valid[0])
        else $error("input stalled with empty first stage");

    // An accepted item lands in the first stage.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (rgb_valid && !rgb_stall) |=> stage_valid[0])
        else $error("accepted item lost at first stage");

endmodule

### tb/sv/rgb_to_hsv_pixel_tb.sv
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_tb;

    import rgbhsv_pkg::*;

    // The run is cut off here if the results stop coming. The slowest
    // correct run is about 1550 items, each waiting out a long sender gap and
    // a long receiver stall plus the pipeline, which is far below this.
    localparam int CYCLE_LIMIT = 2000000;

    // After the last expected result, this many more cycles are watched for
    // results nobody asked for.
    localparam int SETTLE_CYCLES = 40;

    // Only the first few mismatches are printed in full.
    localparam int MAX_REPORTS = 10;

    logic        clk;
    logic        rst_n;
    logic        rgb_valid;
    logic        rgb_stall;
    rgbhsv_rgb_t rgb;
    logic        hsv_valid;
    logic        hsv_stall;
    rgbhsv_hsv_t hsv;

    // Expected HSV items, oldest first, one per accepted pixel.
    rgbhsv_hsv_t pending_hsv[$];

    int unsigned cycle_count = 0;
    int unsigned pixels_sent = 0;
    int unsigned results_checked = 0;
    int unsigned gray_pixels = 0;
    int unsigned mismatches = 0;
    int unsigned input_stall_cycles = 0;

    // Percentages of cycles on which the sender and the receiver start an
    // idle stretch. The tests turn them up and down.
    int unsigned send_gap_pct = 30;
    int unsigned out_stall_pct = 30;

    // When nonzero, the receiver holds off for this many cycles and then
    // clears it.
    int unsigned hold_off_cycles = 0;

    rgb_to_hsv_pixel dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .rgb       (rgb),
        .hsv_valid (hsv_valid),
        .hsv_stall (hsv_stall),
        .hsv       (hsv)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung pipeline or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_hsv.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Length of one idle stretch, drawn from three ranges: mostly the shortest,
    // sometimes the middle one and now and then the longest.
    function automatic int unsigned idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            return $urandom_range(1, 3);
        else if (pick < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Hue offset inside one 60-degree sector: the channel difference scaled
    // to 3840 units and divided by the spread, rounded down.
    function automatic int unsigned sector_offset(int unsigned diff, int unsigned spread);
        return (diff * HUE_SIXTH) / spread;
    endfunction

    // Expected HSV item for one pixel. The largest channel picks the sector,
    // red first on a tie, then green. Gray pixels get hue and saturation 0.
    function automatic rgbhsv_hsv_t hsv_of_pixel(input rgbhsv_rgb_t px);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned top;
        int unsigned bottom;
        int unsigned spread;
        int unsigned hue;
        int unsigned sat;
        rgbhsv_hsv_t res;
        r = 32'(px.red);
        g = 32'(px.green);
        b = 32'(px.blue);
        top = r;
        bottom = r;
        if (g > top) top = g;
        if (b > top) top = b;
        if (g < bottom) bottom = g;
        if (b < bottom) bottom = b;
        spread = top - bottom;
        hue = 0;
        sat = 0;
        if (spread != 0)
        begin
            sat = (spread * SAT_SCALE) / top;
            if (top == r)
            begin
                // Below the red axis the hue wraps from just under 360 degrees.
                if (g >= b)
                    hue = HUE_BASE_RED + sector_offset(g - b, spread);
                else
                    hue = HUE_FULL - sector_offset(b - g, spread);
            end
            else if (top == g)
            begin
                if (b >= r)
                    hue = HUE_BASE_GREEN + sector_offset(b - r, spread);
                else
                    hue = HUE_BASE_GREEN - sector_offset(r - b, spread);
            end
            else
            begin
                if (r >= g)
                    hue = HUE_BASE_BLUE + sector_offset(r - g, spread);
                else
                    hue = HUE_BASE_BLUE - sector_offset(g - r, spread);
            end
        end
        res.hue = hue[14:0];
        res.saturation = sat[7:0];
        res.brightness = top[7:0];
        return res;
    endfunction

    // Offers one pixel and returns in the time step of the edge that took it.
    // Every call starts in the time step of a rising edge, so valid is either
    // kept high for the next item or lowered for a gap, never both in one step.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        rgbhsv_rgb_t px;
        int unsigned gap;
        px.red = r;
        px.green = g;
        px.blue = b;
        gap = 0;
        if ($urandom_range(0, 99) < send_gap_pct)
            gap = idle_len();
        if (gap != 0)
        begin
            rgb_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rgb_valid <= 1'b1;
        rgb <= px;
        do
            @(posedge clk);
        while (rgb_stall);
        pending_hsv.push_back(hsv_of_pixel(px));
        pixels_sent++;
        if (r == g && g == b)
            gray_pixels++;
    endtask

    // The sender goes quiet until every expected result has come back.
    // At least one edge passes so valid is not lowered and raised in one step.
    task automatic pause_until_drained();
        rgb_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_hsv.size() != 0);
    endtask

    // A channel value taken from the ends of the range, just inside them or its middle.
    function automatic logic [7:0] extreme_channel();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd127;
            3: return 8'd128;
            4: return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    // A pixel aimed at the corners of the conversion: grays, ties between two
    // channels, spreads of one or two, extreme channels and plain
    // random pixels.
    task automatic send_corner_pixel();
        logic [7:0] base;
        logic [7:0] other;
        base = 8'($urandom_range(0, 255));
        other = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0: send_pixel(base, base, base);
            1:
            begin
                // Two channels tie; which pair is random.
                case ($urandom_range(0, 2))
                    0: send_pixel(base, base, other);
                    1: send_pixel(other, base, base);
                    default: send_pixel(base, other, base);
                endcase
            end
            2:
            begin
                base = 8'($urandom_range(0, 253));
                send_pixel(8'(base + $urandom_range(0, 2)), 8'(base + $urandom_range(0, 2)),
                           8'(base + $urandom_range(0, 2)));
            end
            3: send_pixel(extreme_channel(), extreme_channel(), extreme_channel());
            default: send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)));
        endcase
    endtask

    // Grays, primaries, every sector on both sides of its axis, every kind
    // of tie for the largest channel, the wrap below the red axis and the
    // smallest possible spreads.
    task automatic test_directed_cases();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd200, 8'd200, 8'd10);
        send_pixel(8'd10, 8'd200, 8'd200);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd10, 8'd200);
        send_pixel(8'd255, 8'd200, 8'd10);
        send_pixel(8'd255, 8'd5, 8'd5);
        send_pixel(8'd200, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd200);
        send_pixel(8'd200, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd200, 8'd255);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd1, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'hAA, 8'h55, 8'hFF);
    endtask

    // Uniform random pixels with idle stretches on both sides.
    task automatic test_random_pixels(input int unsigned count);
        send_gap_pct = 30;
        out_stall_pct = 30;
        repeat (count)
            send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
    endtask

    // One item per clock with neither side idling, the rate a video source
    // needs.
    task automatic test_full_rate(input int unsigned count);
        send_gap_pct = 0;
        out_stall_pct = 0;
        repeat (count)
            send_corner_pixel();
        send_gap_pct = 30;
        out_stall_pct = 30;
    endtask

    // The receiver holds off long enough for the whole chain to fill while
    // the sender keeps offering items, so the input stall has to rise and
    // the block has to resume without losing or repeating an item.
    task automatic test_output_hold();
        send_gap_pct = 0;
        out_stall_pct = 0;
        hold_off_cycles = 80;
        repeat (40)
            send_corner_pixel();
        // Nothing is offered while waiting for the hold-off to end.
        rgb_valid <= 1'b0;
        do
            @(posedge clk);
        while (hold_off_cycles != 0);
        send_gap_pct = 30;
        out_stall_pct = 30;
    endtask

    // Corner pixels in bursts; between bursts the sender waits until the
    // pipeline is empty, so it restarts from an idle block each time.
    task automatic test_drained_bursts(input int unsigned bursts, input int unsigned burst_len);
        repeat (bursts)
        begin
            repeat (burst_len)
                send_corner_pixel();
            pause_until_drained();
        end
    endtask

    // Corner pixels with the usual random idling on both sides.
    task automatic test_corner_pixels(input int unsigned count);
        send_gap_pct = 30;
        out_stall_pct = 30;
        repeat (count)
            send_corner_pixel();
    endtask

    // Receiver: random stall stretches, and a long hold-off on request. The
    // length of the hold-off is counted here, independent of the sender.
    initial
    begin
        int unsigned len;
        hsv_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles != 0)
            begin
                hsv_stall <= 1'b1;
                repeat (hold_off_cycles) @(posedge clk);
                hsv_stall <= 1'b0;
                hold_off_cycles = 0;
            end
            else if ($urandom_range(0, 99) < out_stall_pct)
            begin
                len = idle_len();
                hsv_stall <= 1'b1;
                repeat (len) @(posedge clk);
                hsv_stall <= 1'b0;
            end
        end
    end

    // Result checker. Signals are read in the active region of the edge, so
    // both the outputs of the block and the stall driven here are the values
    // that the edge itself acts on.
    always @(posedge clk)
    begin
        rgbhsv_hsv_t want;
        if (rst_n)
        begin
            if (rgb_valid && rgb_stall)
                input_stall_cycles++;
            if (hsv_valid && !hsv_stall)
            begin
                if (pending_hsv.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Cycle %0d: result with none expected: hue %0d sat %0d val %0d",
                                 cycle_count, hsv.hue, hsv.saturation, hsv.brightness);
                end
                else
                begin
                    want = pending_hsv.pop_front();
                    results_checked++;
                    if (hsv.hue !== want.hue || hsv.saturation !== want.saturation ||
                        hsv.brightness !== want.brightness)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("Cycle %0d: result %0d expected hue %0d sat %0d val %0d,",
                                     cycle_count, results_checked, want.hue,
                                     want.saturation, want.brightness);
                            $display("    got hue %0d sat %0d val %0d",
                                     hsv.hue, hsv.saturation, hsv.brightness);
                        end
                    end
                end
            end
        end
    end

    // Test sequence: reset once, then each test in turn, then drain and
    // report.
    initial
    begin
        rst_n = 1'b0;
        rgb_valid = 1'b0;
        rgb = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_pixels(700);
        test_full_rate(300);
        test_output_hold();
        test_drained_bursts(10, 20);
        test_corner_pixels(300);

        // Wait for the last results, then watch a while longer for strays.
        rgb_valid <= 1'b0;
        while (pending_hsv.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Converted %0d pixels (%0d gray), checked %0d HSV results.",
                 pixels_sent, gray_pixels, results_checked);
        $display("Input was held back on %0d cycles; %0d mismatches in %0d cycles.",
                 input_stall_cycles, mismatches, cycle_count);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### sim.f
rtl/core/rgbhsv_pkg.sv
rtl/core/rgbhsv_prep.sv
rtl/core/rgbhsv_cell.sv
rtl/core/rgb_to_hsv_pixel.sv
tb/sv/rgb_to_hsv_pixel_tb.sv
